### rtl/msbm_pkg.sv
// shared types and constants of the multi-signature byte matcher
package msbm_pkg;

    localparam int NUM_SIGS = 16;
    localparam int SIG_LEN  = 32;

    localparam int IDX_W  = 4;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 16;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [NUM_SIGS-1:0] sig_mask_t;

    localparam cnt_t CNT_MAX = '1;
    localparam len_t LEN_MAX = len_t'(SIG_LEN);

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_LENGTH  = 2'd1,
        ACT_SCAN    = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

endpackage

### rtl/multi_signature_byte_matcher_top.sv
// multi-signature byte matcher: signature table, scan window and match reporting
//
// The block keeps a table of sixteen byte signatures of up to 32 bytes each and scans a
// byte stream for all of them at once. Each request carries an action in tuser: write one
// signature byte, set a signature length (zero empties the entry, above 32 is clamped),
// scan one stream byte, or restart the scan (clears the window and the byte counter).
// Every scan byte is checked against all enabled signatures in parallel; each exact match
// produces one result at its last byte, in ascending signature index, carrying the offset
// of its first byte since restart, and tlast marks the final result of that byte. The byte
// counter stops at 65535; from then on tuser flags the offset as saturated (offset is then
// 65535 minus the signature length). A request is taken every cycle as long as results
// drain and no realignment is in progress: a scan byte that matches several signatures
// holds the output until each is reported, and the next request waits behind them;
// results leave through a single output register. Setting a nonzero length copies that
// entry's bytes from the signature memory into the compare lanes one byte per cycle, so
// the request after it waits until the copy is done; a zero length costs nothing extra.
// Signature bytes read before being written are undefined.
module multi_signature_byte_matcher_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sig_index[3:0], sig_pos[8:4], sig_length[14:9], data_byte[22:15], zero[23]
    input  logic [msbm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [msbm_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // match_index[3:0], start_offset[19:4], zero[23:20]
    output logic [msbm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // offset_saturated[0]
    output logic [msbm_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);

    // input register
    logic                in_valid_reg;
    msbm_pkg::action_t   in_act_reg;
    msbm_pkg::idx_t      in_idx_reg;
    msbm_pkg::pos_t      in_pos_reg;
    msbm_pkg::len_t      in_len_reg;
    msbm_pkg::byte_t     in_byte_reg;

    // signature table: raw bytes in memory, addressed by {index, position},
    // and a copy aligned to the window
    // (aln_reg[i][j] holds the byte that must sit j places back from the newest byte)
    msbm_pkg::byte_t     raw_mem [msbm_pkg::NUM_SIGS * msbm_pkg::SIG_LEN];
    msbm_pkg::byte_t     aln_reg [msbm_pkg::NUM_SIGS][msbm_pkg::SIG_LEN];
    msbm_pkg::len_t      len_reg [msbm_pkg::NUM_SIGS];

    // realignment of one entry after a length set, one raw byte per cycle
    logic                rl_busy_reg;
    msbm_pkg::idx_t      rl_idx_reg;
    msbm_pkg::len_t      rl_len_reg;
    msbm_pkg::pos_t      rl_pos_reg;
    logic                rl_wr_reg;
    msbm_pkg::pos_t      rl_dst_reg;
    msbm_pkg::byte_t     rl_data_reg;

    // scan state, window index 0 is the newest byte
    msbm_pkg::byte_t     win_reg [msbm_pkg::SIG_LEN];
    msbm_pkg::cnt_t      cnt_reg;

    // matches of one scan byte still to be reported
    msbm_pkg::sig_mask_t pend_mask_reg;
    msbm_pkg::cnt_t      pend_base_reg;
    logic                pend_sat_reg;

    // output register
    logic                out_valid_reg;
    msbm_pkg::idx_t      out_idx_reg;
    msbm_pkg::cnt_t      out_off_reg;
    logic                out_sat_reg;
    logic                out_last_reg;

    // handshake and flow control
    logic                out_load;
    logic                pend_any;
    msbm_pkg::sig_mask_t pend_rest;
    logic                pend_free;
    logic                b_adv;
    logic                do_write;
    logic                do_length;
    logic                do_scan;
    logic                do_restart;

    // datapath
    msbm_pkg::byte_t     win_shift [msbm_pkg::SIG_LEN];
    msbm_pkg::cnt_t      cnt_next;
    msbm_pkg::sig_mask_t match_vec;
    msbm_pkg::len_t      len_clamp;
    msbm_pkg::pos_t      wr_dst [msbm_pkg::NUM_SIGS];
    msbm_pkg::idx_t      sel_idx;
    msbm_pkg::cnt_t      sel_off;
    logic                rl_last;
    msbm_pkg::pos_t      rl_dst;

    // the next stage can take a request when the pending set empties this cycle
    // and no realignment is in progress
    assign out_load  = !out_valid_reg || m_axis_tready;
    assign pend_any  = |pend_mask_reg;
    assign pend_rest = pend_mask_reg & (pend_mask_reg - msbm_pkg::sig_mask_t'(1));
    assign pend_free = !pend_any || ((pend_rest == '0) && out_load);
    assign b_adv     = in_valid_reg && pend_free && !rl_busy_reg && !rl_wr_reg;

    assign s_axis_tready = !in_valid_reg || b_adv;

    always_comb
    begin
        do_write   = 1'b0;
        do_length  = 1'b0;
        do_scan    = 1'b0;
        do_restart = 1'b0;
        unique case (in_act_reg)
            msbm_pkg::ACT_WRITE:   do_write   = b_adv;
            msbm_pkg::ACT_LENGTH:  do_length  = b_adv;
            msbm_pkg::ACT_SCAN:    do_scan    = b_adv;
            msbm_pkg::ACT_RESTART: do_restart = b_adv;
            default:               do_scan    = 1'b0;
        endcase
    end

    // window after the scan byte is shifted in, and saturating counter
    always_comb
    begin
        win_shift[0] = in_byte_reg;
        for (int j = 1; j < msbm_pkg::SIG_LEN; j++)
        begin
            win_shift[j] = win_reg[j-1];
        end
    end

    assign cnt_next = (cnt_reg == msbm_pkg::CNT_MAX) ? cnt_reg
                                                     : cnt_reg + msbm_pkg::cnt_t'(1);

    // all signatures against the shifted window, masked by each length
    always_comb
    begin
        for (int i = 0; i < msbm_pkg::NUM_SIGS; i++)
        begin
            match_vec[i] = (len_reg[i] != '0) &&
                           (msbm_pkg::cnt_t'(len_reg[i]) <= cnt_next);
            for (int j = 0; j < msbm_pkg::SIG_LEN; j++)
            begin
                if ((msbm_pkg::len_t'(j) < len_reg[i]) && (aln_reg[i][j] != win_shift[j]))
                begin
                    match_vec[i] = 1'b0;
                end
            end
        end
    end

    assign len_clamp = (in_len_reg > msbm_pkg::LEN_MAX) ? msbm_pkg::LEN_MAX : in_len_reg;

    // realignment walks raw positions 0 to length-1
    assign rl_last = (msbm_pkg::len_t'(rl_pos_reg) == (rl_len_reg - msbm_pkg::len_t'(1)));
    assign rl_dst  = msbm_pkg::pos_t'(rl_len_reg - msbm_pkg::len_t'(1)
                                      - msbm_pkg::len_t'(rl_pos_reg));

    // aligned place of a written byte, per signature lane
    always_comb
    begin
        for (int i = 0; i < msbm_pkg::NUM_SIGS; i++)
        begin
            wr_dst[i] = msbm_pkg::pos_t'(len_reg[i] - msbm_pkg::len_t'(1)
                                         - msbm_pkg::len_t'(in_pos_reg));
        end
    end

    // lowest pending match goes out first
    always_comb
    begin
        sel_idx = '0;
        for (int i = msbm_pkg::NUM_SIGS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
            begin
                sel_idx = msbm_pkg::idx_t'(i);
            end
        end
    end

    assign sel_off = pend_base_reg - msbm_pkg::cnt_t'(len_reg[sel_idx]);

    // control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int i = 0; i < msbm_pkg::NUM_SIGS; i++)
            begin
                len_reg[i] <= '0;
            end
            for (int j = 0; j < msbm_pkg::SIG_LEN; j++)
            begin
                win_reg[j] <= '0;
            end
            cnt_reg       <= '0;
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
            rl_busy_reg   <= 1'b0;
            rl_wr_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (do_length)
            begin
                len_reg[in_idx_reg] <= len_clamp;
            end

            // a nonzero length starts the copy into the compare lanes
            if (do_length && (len_clamp != '0))
            begin
                rl_busy_reg <= 1'b1;
            end
            else if (rl_busy_reg && rl_last)
            begin
                rl_busy_reg <= 1'b0;
            end
            rl_wr_reg <= rl_busy_reg;

            if (do_scan)
            begin
                for (int j = 0; j < msbm_pkg::SIG_LEN; j++)
                begin
                    win_reg[j] <= win_shift[j];
                end
                cnt_reg <= cnt_next;
            end
            else if (do_restart)
            begin
                for (int j = 0; j < msbm_pkg::SIG_LEN; j++)
                begin
                    win_reg[j] <= '0;
                end
                cnt_reg <= '0;
            end

            if (do_scan)
            begin
                pend_mask_reg <= match_vec;
            end
            else if (out_load && pend_any)
            begin
                pend_mask_reg <= pend_rest;
            end

            if (out_load)
            begin
                out_valid_reg <= pend_any;
            end
        end
    end

    // payload registers and signature memory
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_act_reg  <= msbm_pkg::action_t'(s_axis_tuser[1:0]);
            in_idx_reg  <= s_axis_tdata[3:0];
            in_pos_reg  <= s_axis_tdata[8:4];
            in_len_reg  <= s_axis_tdata[14:9];
            in_byte_reg <= s_axis_tdata[22:15];
        end

        if (do_write)
        begin
            raw_mem[{in_idx_reg, in_pos_reg}] <= in_byte_reg;
        end

        if (do_length)
        begin
            rl_idx_reg <= in_idx_reg;
            rl_len_reg <= len_clamp;
            rl_pos_reg <= '0;
        end
        else if (rl_busy_reg)
        begin
            rl_pos_reg <= rl_pos_reg + msbm_pkg::pos_t'(1);
        end

        if (rl_busy_reg)
        begin
            rl_data_reg <= raw_mem[{rl_idx_reg, rl_pos_reg}];
            rl_dst_reg  <= rl_dst;
        end

        for (int i = 0; i < msbm_pkg::NUM_SIGS; i++)
        begin
            if (do_write && (in_idx_reg == msbm_pkg::idx_t'(i)) &&
                (msbm_pkg::len_t'(in_pos_reg) < len_reg[i]))
            begin
                aln_reg[i][wr_dst[i]] <= in_byte_reg;
            end
        end

        if (rl_wr_reg)
        begin
            aln_reg[rl_idx_reg][rl_dst_reg] <= rl_data_reg;
        end

        if (do_scan)
        begin
            pend_base_reg <= cnt_next;
            pend_sat_reg  <= (cnt_next == msbm_pkg::CNT_MAX);
        end

        if (out_load && pend_any)
        begin
            out_idx_reg  <= sel_idx;
            out_off_reg  <= sel_off;
            out_sat_reg  <= pend_sat_reg;
            out_last_reg <= (pend_rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_off_reg, out_idx_reg};
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // a new request never enters while more than one match is still queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_rest != '0) |-> !b_adv)
    else $error("request advanced over queued matches");

    // a result without tlast is always followed by more queued matches
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> pend_any)
    else $error("result without tlast but nothing queued");

    // the saturation flag agrees with the stored byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_any |-> (pend_sat_reg == (pend_base_reg == msbm_pkg::CNT_MAX)))
    else $error("saturation flag out of step with byte count");

    // a reported offset never lies beyond the scanned byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pend_any) |-> (sel_off <= pend_base_reg))
    else $error("start offset beyond byte count");
`endif

endmodule
